FILE: sv/sle_pkg.sv
// Shared constants and types for the sequential list engine.
// Used by sle_ram, sle_seq and sequential_list_engine; depends on nothing.
`default_nettype none

package sle_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int POS_W        = 9;
    localparam int VAL_W        = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd3;

    typedef struct packed {
        logic                       done;
        logic [STATUS_W-1:0]        status;
        logic signed [VAL_W-1:0]    out_value;
        logic [POS_W-1:0]           found_position;
        logic [POS_W-1:0]           list_length;
        logic                       is_empty;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/sequential_list_engine.sv
// Ordered list of signed 32-bit values with 1-based positions; a command is
// taken while busy is low and gives one result, shown for a single cycle with
// done high. The receiver cannot hold results off, so sample them on done.
// Insert moves every entry from the position to the tail up one place, or
// nothing at the tail; delete moves every entry after the position down one;
// locate compares entries from the head until the first match. All moves and
// compares go through the store's single read and write port pair. The store
// is not cleared after reset; only entries below the current length are ever
// read.
// Depends on sle_pkg, sle_seq and sle_ram.
`default_nettype none

module sequential_list_engine #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [sle_pkg::CMD_W-1:0]          command,
    input  wire logic [sle_pkg::POS_W-1:0]          position,
    input  wire logic signed [sle_pkg::VAL_W-1:0]   value,
    output logic                                    done,
    output logic [sle_pkg::STATUS_W-1:0]            status,
    output logic signed [sle_pkg::VAL_W-1:0]        out_value,
    output logic [sle_pkg::POS_W-1:0]               found_position,
    output logic [sle_pkg::POS_W-1:0]               list_length,
    output logic                                    is_empty
);

    localparam int AW = $clog2(CAPACITY);

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [sle_pkg::VAL_W-1:0]   wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [sle_pkg::VAL_W-1:0]   rd_data;
    sle_pkg::result_t            result;

    logic                              done_reg;
    logic [sle_pkg::STATUS_W-1:0]      status_reg;
    logic signed [sle_pkg::VAL_W-1:0]  out_value_reg;
    logic [sle_pkg::POS_W-1:0]         found_reg;
    logic [sle_pkg::POS_W-1:0]         length_reg;
    logic                              empty_reg;

    sle_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .command  (command),
        .position (position),
        .value    (value),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .result   (result)
    );

    sle_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // register the done strobe; the result fields below are held until the next done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= result.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.done)
        begin
            status_reg    <= result.status;
            out_value_reg <= result.out_value;
            found_reg     <= result.found_position;
            length_reg    <= result.list_length;
            empty_reg     <= result.is_empty;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign out_value      = out_value_reg;
    assign found_position = found_reg;
    assign list_length    = length_reg;
    assign is_empty       = empty_reg;

endmodule

`default_nettype wire

FILE: sv/sle_ram.sv
// Element store: one write port and one registered read port.
// Depends on sle_pkg for the element width.
`default_nettype none

module sle_ram #(
    parameter int DEPTH = sle_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [sle_pkg::VAL_W-1:0]    wr_data,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output logic [sle_pkg::VAL_W-1:0]         rd_data
);

    logic [sle_pkg::VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/sle_seq.sv
// Command sequencer: element count, range checks and the shift/scan loop that
// walks the element store one entry a cycle. Depends on sle_pkg.
`default_nettype none

module sle_seq #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [sle_pkg::CMD_W-1:0]          command,
    input  wire logic [sle_pkg::POS_W-1:0]          position,
    input  wire logic signed [sle_pkg::VAL_W-1:0]   value,
    output logic                                    wr_en,
    output logic [AW-1:0]                           wr_addr,
    output logic [sle_pkg::VAL_W-1:0]               wr_data,
    output logic                                    rd_en,
    output logic [AW-1:0]                           rd_addr,
    input  wire logic [sle_pkg::VAL_W-1:0]          rd_data,
    output sle_pkg::result_t                        result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISPATCH  = 3'd1;
    localparam logic [2:0] S_INS_SHIFT = 3'd2;
    localparam logic [2:0] S_INS_PUT   = 3'd3;
    localparam logic [2:0] S_DEL_SHIFT = 3'd4;
    localparam logic [2:0] S_GET_WAIT  = 3'd5;
    localparam logic [2:0] S_LOC_SCAN  = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0]                         state_reg, state_next;
    logic [sle_pkg::CMD_W-1:0]          cmd_reg, cmd_next;
    logic [sle_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [sle_pkg::VAL_W-1:0]          val_reg, val_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [CW-1:0]                      ptr_reg, ptr_next;
    logic [sle_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [sle_pkg::VAL_W-1:0]          outv_reg, outv_next;
    logic [sle_pkg::POS_W-1:0]          found_reg, found_next;

    logic [XW-1:0] cnt_x;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] pos_m1;
    logic [XW-1:0] ptr_x;
    logic [XW-1:0] last_x;
    logic          is_full;
    logic          pos_in_list;
    logic          pos_in_ins;

    assign cnt_x       = XW'(count_reg);
    assign pos_x       = XW'(pos_reg);
    assign pos_m1      = pos_x - XW'(1);
    assign ptr_x       = XW'(ptr_reg);
    assign last_x      = cnt_x - XW'(1);
    assign is_full     = (cnt_x >= XW'(CAPACITY));
    assign pos_in_list = (pos_x != '0) && (pos_x <= cnt_x);
    assign pos_in_ins  = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        status_next = status_reg;
        outv_next   = outv_reg;
        found_next  = found_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_m1[AW-1:0];
        wr_data     = val_reg;
        rd_en       = 1'b0;
        rd_addr     = pos_m1[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = command;
                    pos_next    = position;
                    val_next    = value;
                    status_next = sle_pkg::ST_OK;
                    outv_next   = '0;
                    found_next  = '0;
                    state_next  = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                state_next = S_DONE;
                unique case (cmd_reg)
                    sle_pkg::CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    sle_pkg::CMD_APPEND:
                    begin
                        if (is_full)
                        begin
                            status_next = sle_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = cnt_x[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    sle_pkg::CMD_INSERT:
                    begin
                        if (is_full)
                        begin
                            status_next = sle_pkg::ST_FULL;
                        end
                        else if (!pos_in_ins)
                        begin
                            status_next = sle_pkg::ST_BADPOS;
                        end
                        else if (pos_x == cnt_x + XW'(1))
                        begin
                            // insert at the tail: nothing to move
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = last_x[AW-1:0];
                            ptr_next   = CW'(last_x);
                            state_next = S_INS_SHIFT;
                        end
                    end
                    sle_pkg::CMD_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = sle_pkg::ST_MISS;
                        end
                        else if (!pos_in_list)
                        begin
                            status_next = sle_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            ptr_next   = CW'(pos_m1);
                            state_next = S_DEL_SHIFT;
                        end
                    end
                    sle_pkg::CMD_GET:
                    begin
                        if (!pos_in_list)
                        begin
                            status_next = sle_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = S_GET_WAIT;
                        end
                    end
                    sle_pkg::CMD_MODIFY:
                    begin
                        if (!pos_in_list)
                        begin
                            status_next = sle_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                        end
                    end
                    sle_pkg::CMD_LOCATE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = sle_pkg::ST_MISS;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            ptr_next   = '0;
                            state_next = S_LOC_SCAN;
                        end
                    end
                    default:
                    begin
                        status_next = sle_pkg::ST_OK;
                    end
                endcase
            end

            S_INS_SHIFT:
            begin
                // rd_data holds the entry at ptr; move it up one place
                wr_en   = 1'b1;
                wr_addr = AW'(ptr_x + XW'(1));
                wr_data = rd_data;
                if (ptr_x == pos_m1)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(ptr_x - XW'(1));
                    ptr_next = ptr_reg - CW'(1);
                end
            end

            S_INS_PUT:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            S_DEL_SHIFT:
            begin
                if (ptr_x == pos_m1)
                begin
                    outv_next = rd_data;
                end
                else
                begin
                    // close the gap: drop this entry one place down
                    wr_en   = 1'b1;
                    wr_addr = AW'(ptr_x - XW'(1));
                    wr_data = rd_data;
                end
                if (ptr_x == last_x)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(ptr_x + XW'(1));
                    ptr_next = ptr_reg + CW'(1);
                end
            end

            S_GET_WAIT:
            begin
                outv_next  = rd_data;
                state_next = S_DONE;
            end

            S_LOC_SCAN:
            begin
                if (rd_data == val_reg)
                begin
                    found_next  = sle_pkg::POS_W'(ptr_x + XW'(1));
                    status_next = sle_pkg::ST_OK;
                    state_next  = S_DONE;
                end
                else if (ptr_x == last_x)
                begin
                    status_next = sle_pkg::ST_MISS;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(ptr_x + XW'(1));
                    ptr_next = ptr_reg + CW'(1);
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.done           = (state_reg == S_DONE);
        result.status         = status_reg;
        result.out_value      = outv_reg;
        result.found_position = found_reg;
        result.list_length    = cnt_x[sle_pkg::POS_W-1:0];
        result.is_empty       = (count_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        outv_reg   <= outv_next;
        found_reg  <= found_next;
    end

endmodule

`default_nettype wire

FILE: sim/tb_sequential_list_engine.sv
// Self-checking testbench for sequential_list_engine: directed and random commands
// checked against an in-bench list model, one result per accepted command.
// Depends on sle_pkg and the sequential_list_engine RTL only.
module tb_sequential_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    localparam int LIST_CAP   = CAPACITY_DEF;
    localparam int PHASE_LEN  = 300;
    localparam int DRAIN_WAIT = LIST_CAP + 50;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] out_value;
        logic [POS_W-1:0]        found_position;
        logic [POS_W-1:0]        list_length;
        logic                    is_empty;
    } list_result_t;

    typedef enum int {EP_MIXED, EP_GROW, EP_SHRINK, EP_NOISE, EP_FILL} episode_e;

    class list_scoreboard;
        logic signed [VAL_W-1:0] elems [LIST_CAP];
        int                      count;
        list_result_t            pending [$];
        int                      errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Apply one accepted command to the list copy and queue its result.
        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] val);
            list_result_t r;
            int           p;
            int           k;
            r      = '0;
            r.status = ST_OK;
            p      = int'(pos);
            case (cmd)
                CMD_CLEAR: count = 0;
                CMD_APPEND:
                    if (count >= LIST_CAP)
                        r.status = ST_FULL;
                    else
                    begin
                        elems[count] = val;
                        count++;
                    end
                CMD_INSERT:
                    if (count >= LIST_CAP)
                        r.status = ST_FULL;
                    else if (p < 1 || p > count + 1)
                        r.status = ST_BADPOS;
                    else
                    begin
                        for (k = count; k >= p; k--)
                            elems[k] = elems[k-1];
                        elems[p-1] = val;
                        count++;
                    end
                CMD_DELETE:
                    if (count == 0)
                        r.status = ST_MISS;
                    else if (p < 1 || p > count)
                        r.status = ST_BADPOS;
                    else
                    begin
                        r.out_value = elems[p-1];
                        for (k = p; k < count; k++)
                            elems[k-1] = elems[k];
                        count--;
                    end
                CMD_GET:
                    if (p < 1 || p > count)
                        r.status = ST_BADPOS;
                    else
                        r.out_value = elems[p-1];
                CMD_MODIFY:
                    if (p < 1 || p > count)
                        r.status = ST_BADPOS;
                    else
                        elems[p-1] = val;
                CMD_LOCATE:
                begin
                    r.status = ST_MISS;
                    for (k = 0; k < count; k++)
                    begin
                        if (elems[k] == val)
                        begin
                            r.found_position = POS_W'(k + 1);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            r.list_length = POS_W'(count);
            r.is_empty    = (count == 0);
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [VAL_W:0] exp_v,
                                    logic signed [VAL_W:0] got_v);
            if (got_v !== exp_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(list_result_t got);
            list_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result with no command outstanding");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            compare_field("status", exp_r.status, got.status);
            compare_field("out_value", exp_r.out_value, got.out_value);
            compare_field("found_position", exp_r.found_position, got.found_position);
            compare_field("list_length", exp_r.list_length, got.list_length);
            compare_field("is_empty", exp_r.is_empty, got.is_empty);
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic                    done;
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] out_value;
    logic [POS_W-1:0]        found_position;
    logic [POS_W-1:0]        list_length;
    logic                    is_empty;

    list_scoreboard sb = new();
    list_result_t   seen;
    int             idle_pct;
    int             issued;

    sequential_list_engine i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .position       (position),
        .value          (value),
        .done           (done),
        .status         (status),
        .out_value      (out_value),
        .found_position (found_position),
        .list_length    (list_length),
        .is_empty       (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen = '{status, out_value, found_position, list_length, is_empty};
            sb.check_result(seen);
        end
    end

    // Present one command from a falling edge and hold it until it is taken.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                         input logic signed [VAL_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start    = 1'b0;
            command  = CMD_W'($urandom);
            position = POS_W'($urandom);
            value    = $urandom;
            @(negedge clk);
        end
        start    = 1'b1;
        command  = cmd;
        position = pos;
        value    = val;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_command(cmd, pos, val);
        issued++;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 8)) - 32'sd4;
            3:
                case ($urandom_range(0, 3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            default: return $urandom;
        endcase
    endfunction

    // Mostly a legal position in 1..hi; otherwise one just out of range or far off.
    function automatic logic [POS_W-1:0] pick_pos(int hi, int bad_pct);
        if (hi < 1 || $urandom_range(99) < bad_pct)
            case ($urandom_range(0, 2))
                0: return '0;
                1: return POS_W'(hi + 1);
                default: return POS_W'($urandom_range(hi + 1, (1 << POS_W) - 1));
            endcase
        return POS_W'($urandom_range(1, hi));
    endfunction

    task automatic random_item(episode_e mode);
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] val;
        int                      r;
        r = $urandom_range(99);
        case (mode)
            EP_GROW:   cmd = r < 50 ? CMD_APPEND : r < 85 ? CMD_INSERT
                           : r < 93 ? CMD_GET : CMD_LOCATE;
            EP_SHRINK: cmd = r < 55 ? CMD_DELETE : r < 70 ? CMD_GET
                           : r < 85 ? CMD_LOCATE : CMD_MODIFY;
            EP_NOISE:
            begin
                issue(CMD_W'($urandom_range(0, 7)), POS_W'($urandom), $urandom);
                return;
            end
            default:   cmd = r < 3 ? CMD_CLEAR : r < 30 ? CMD_APPEND
                           : r < 45 ? CMD_INSERT : r < 60 ? CMD_DELETE
                           : r < 75 ? CMD_GET : r < 85 ? CMD_MODIFY : CMD_LOCATE;
        endcase
        val = pick_value();
        // Search mostly for keys that are present, duplicates included.
        if (cmd == CMD_LOCATE && sb.count > 0 && $urandom_range(99) < 60)
            val = sb.elems[$urandom_range(0, sb.count - 1)];
        if (cmd == CMD_INSERT)
            issue(cmd, pick_pos(sb.count + 1, 10), val);
        else
            issue(cmd, pick_pos(sb.count, 10), val);
    endtask

    task automatic fill_list();
        while (sb.count < LIST_CAP)
        begin
            if ($urandom_range(99) < 75)
                issue(CMD_APPEND, pick_pos(sb.count, 0), pick_value());
            else
                issue(CMD_INSERT, pick_pos(sb.count + 1, 0), pick_value());
        end
        // Hammer the full list before letting it drain.
        issue(CMD_APPEND, '0, pick_value());
        issue(CMD_INSERT, pick_pos(sb.count, 0), pick_value());
        issue(CMD_INSERT, '0, pick_value());
        issue(CMD_GET, POS_W'(LIST_CAP), '0);
        issue(CMD_LOCATE, '0, sb.elems[LIST_CAP-1]);
        issue(CMD_DELETE, 9'd1, '0);
        issue(CMD_INSERT, 9'd1, pick_value());
        repeat (10) random_item(EP_SHRINK);
    endtask

    initial
    begin
        episode_e mode;
        int       ph;
        int       target;
        rst_n    = 1'b0;
        start    = 1'b0;
        command  = CMD_CLEAR;
        position = '0;
        value    = '0;
        idle_pct = 0;
        issued   = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Empty-list refusals.
        issue(CMD_GET, 9'd1, '0);
        issue(CMD_DELETE, 9'd1, '0);
        issue(CMD_LOCATE, '0, '0);
        issue(CMD_MODIFY, 9'd1, 32'sd9);
        issue(CMD_INSERT, 9'd2, 32'sd9);
        issue(CMD_INSERT, '0, 32'sd9);
        // Build a short list at head, tail and middle.
        issue(CMD_INSERT, 9'd1, 32'sh7fffffff);
        issue(CMD_APPEND, '0, 32'sh80000000);
        issue(CMD_APPEND, '0, -32'sd1);
        issue(CMD_INSERT, 9'd4, 32'sd0);
        issue(CMD_INSERT, 9'd2, 32'sd5);
        issue(CMD_GET, 9'd1, '0);
        issue(CMD_GET, 9'd5, '0);
        issue(CMD_GET, 9'd6, '0);
        issue(CMD_GET, '0, '0);
        // Duplicate key: locate must return the first match.
        issue(CMD_MODIFY, 9'd3, 32'sd5);
        issue(CMD_LOCATE, '0, 32'sd5);
        issue(CMD_LOCATE, '0, 32'sd12345);
        issue(CMD_DELETE, 9'd511, '0);
        issue(CMD_DELETE, '0, '0);
        issue(CMD_DELETE, 9'd2, '0);
        issue(CMD_DELETE, 9'd4, '0);
        issue(CMD_LOCATE, '0, -32'sd1);
        issue(CMD_UNUSED, 9'd511, 32'sh5a5a5a5a);
        // After clear, a value from before the clear must not be found.
        issue(CMD_CLEAR, '0, '0);
        issue(CMD_APPEND, '0, 32'sd42);
        issue(CMD_LOCATE, '0, 32'sh7fffffff);

        for (ph = 0; ph < 3; ph++)
        begin
            idle_pct = ph == 0 ? 14 : ph == 1 ? 85 : 0;
            target   = issued + PHASE_LEN;
            if (ph == 0)
                fill_list();
            while (issued < target)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: mode = EP_MIXED;
                    4, 5:       mode = EP_GROW;
                    6, 7:       mode = EP_SHRINK;
                    8:          mode = EP_NOISE;
                    default:    mode = EP_FILL;
                endcase
                if (mode == EP_FILL)
                    fill_list();
                else
                    repeat ($urandom_range(15, 50)) random_item(mode);
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        // Catch any stray strobe after the last result.
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
sv/sle_pkg.sv
sv/sle_ram.sv
sv/sle_seq.sv
sv/sequential_list_engine.sv
sim/tb_sequential_list_engine.sv
